[src/chne_pkg.sv]
// shared types and constants for the channel histogram entropy block
package chne_pkg;

  localparam int unsigned BIN_N = 256;
  localparam int unsigned BIN_W = 8;
  localparam int unsigned CNT_W = 25;
  localparam int unsigned LOG_FRAC = 20;
  localparam int unsigned LOG_W = 25;
  localparam int unsigned ACC_W = 51;
  localparam int unsigned DVD_W = 52;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW = 2;

  localparam logic [CNT_W-1:0] MAX_PIXELS = 25'd16777216;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [18:0] ENTROPY_MAX = 19'd393215;

  localparam logic [1:0] SEL_BLUE = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last_pixel;
  } in_word_t;

  typedef struct packed {
    logic [18:0] entropy;
    logic [24:0] pixel_total;
  } out_word_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             last;
  } q_word_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_stat_t;

  typedef enum logic [3:0] {
    B_CLR, B_IDLE, B_UPD, B_SRD, B_SCHK, B_SLOG, B_SACC,
    B_NLOG, B_NWAIT, B_NMUL, B_DIV, B_EMUL, B_OUT
  } back_st_t;

endpackage

[src/chne_queue.sv]
// short queue of classified pixel words between front and back
module chne_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  chne_pkg::q_word_t push_word,
  input  logic             pop,
  output chne_pkg::q_word_t pop_word,
  output logic             empty,
  output logic             full
);
  import chne_pkg::*;

  q_word_t         slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign empty = (cnt_r == '0);
  assign full = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_word = slot_r[rp_r];

  always_comb begin
    wp_nxt = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_word;
    end
  end

endmodule

[src/chne_front.sv]
// input side: channel select register and byte classification
module chne_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  chne_pkg::in_word_t in_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  input  logic              q_full,
  input  chne_pkg::back_stat_t stat,
  output logic              push,
  output chne_pkg::q_word_t push_word
);
  import chne_pkg::*;

  logic [1:0] sel_r, sel_nxt;

  assign cfg_ready = 1'b1;
  assign busy = q_full || stat.clearing;
  assign push = start && !busy;
  assign sel_nxt = (cfg_valid && cfg_ready) ? cfg_data : sel_r;

  always_comb begin
    push_word.last = in_word.last_pixel;
    priority case (sel_r)
      SEL_BLUE:  push_word.bin = in_word.blue;
      SEL_GREEN: push_word.bin = in_word.green;
      default:   push_word.bin = in_word.red;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

[src/chne_log.sv]
// iterative log2 in q.20, one mantissa squaring per cycle
module chne_log (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      log_start,
  input  logic [chne_pkg::CNT_W-1:0] x,
  output logic                      done,
  output logic [chne_pkg::LOG_W-1:0] res
);
  import chne_pkg::*;

  logic [4:0]          k_r, k_nxt, k_c;
  logic [31:0]         y_r, y_nxt;
  logic [LOG_FRAC-1:0] frac_r, frac_nxt;
  logic [4:0]          step_r, step_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [63:0]         sq;
  logic [32:0]         t;

  always_comb begin
    k_c = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (x[i]) k_c = 5'(i);
    end
  end

  assign sq = y_r * y_r;
  assign t = sq[63:31];
  assign res = {k_r, frac_r};
  assign done = done_r;

  always_comb begin
    k_nxt = k_r;
    y_nxt = y_r;
    frac_nxt = frac_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (log_start) begin
      k_nxt = k_c;
      y_nxt = {7'b0, x} << (5'd31 - k_c);
      frac_nxt = '0;
      step_nxt = 5'(LOG_FRAC);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      y_nxt = t[32] ? t[32:1] : t[31:0];
      frac_nxt = {frac_r[LOG_FRAC-2:0], t[32]};
      step_nxt = step_r - 1'b1;
      if (step_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    y_r <= y_nxt;
    frac_r <= frac_nxt;
  end

endmodule

[src/chne_back.sv]
// back side: histogram memory, bin scan, entropy arithmetic
module chne_back (
  input  logic                clk,
  input  logic                rst_n,
  input  chne_pkg::q_word_t   q_word,
  input  logic                q_empty,
  output logic                pop,
  output chne_pkg::back_stat_t stat,
  output logic                out_valid,
  output chne_pkg::out_word_t out_word
);
  import chne_pkg::*;

  back_st_t         st_r, st_nxt;
  logic [CNT_W-1:0] mem [BIN_N];
  logic [CNT_W-1:0] rdata_r;
  logic             rd_en, we;
  logic [BIN_W-1:0] raddr, waddr;
  logic [CNT_W-1:0] wdata;

  logic [BIN_W-1:0] idx_r, idx_nxt, bin_r, bin_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, c_r, c_nxt;
  logic [ACC_W-1:0] s_r, s_nxt, prod_r, prod_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [5:0]       dstep_r, dstep_nxt;
  logic [57:0]      eprod_r, eprod_nxt;
  logic             qhi_r, qhi_nxt;
  logic             ov_r, ov_nxt;
  out_word_t        ow_r, ow_nxt;

  logic             log_start, log_done;
  logic [CNT_W-1:0] log_x;
  logic [LOG_W-1:0] log_res;
  logic [CNT_W-1:0] mul_a;
  logic [49:0]      mul_p;
  logic [CNT_W:0]   rem2;
  logic [ACC_W-1:0] tdiff;
  logic [58:0]      esum;
  logic [22:0]      e;

  chne_log u_log (
    .clk(clk), .rst_n(rst_n), .log_start(log_start), .x(log_x),
    .done(log_done), .res(log_res)
  );

  assign mul_a = (st_r == B_SLOG) ? c_r : cnt_r;
  assign mul_p = mul_a * log_res;
  assign rem2 = {rem_r, dvd_r[DVD_W-1]};
  assign tdiff = (prod_r > s_r) ? prod_r - s_r : '0;
  assign esum = {1'b0, eprod_r} + 59'h8_0000_0000;
  assign e = esum[58:36];
  assign stat.clearing = (st_r == B_CLR);
  assign stat.idle = (st_r == B_IDLE);
  assign out_valid = ov_r;
  assign out_word = ow_r;

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    bin_nxt = bin_r;
    last_nxt = last_r;
    cnt_nxt = cnt_r;
    c_nxt = c_r;
    s_nxt = s_r;
    prod_nxt = prod_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dstep_nxt = dstep_r;
    eprod_nxt = eprod_r;
    qhi_nxt = qhi_r;
    ov_nxt = 1'b0;
    ow_nxt = ow_r;
    rd_en = 1'b0;
    raddr = idx_r;
    we = 1'b0;
    waddr = idx_r;
    wdata = '0;
    pop = 1'b0;
    log_start = 1'b0;
    log_x = c_r;
    unique case (st_r)
      B_CLR: begin
        we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == BIN_W'(BIN_N - 1)) st_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          rd_en = 1'b1;
          raddr = q_word.bin;
          bin_nxt = q_word.bin;
          last_nxt = q_word.last;
          st_nxt = B_UPD;
        end
      end
      B_UPD: begin
        if (cnt_r < MAX_PIXELS) begin
          we = 1'b1;
          waddr = bin_r;
          wdata = rdata_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (last_r) begin
          idx_nxt = '0;
          s_nxt = '0;
          st_nxt = B_SRD;
        end else begin
          st_nxt = B_IDLE;
        end
      end
      B_SRD: begin
        rd_en = 1'b1;
        st_nxt = B_SCHK;
      end
      B_SCHK: begin
        we = 1'b1;
        c_nxt = rdata_r;
        if (rdata_r >= CNT_W'(2)) begin
          log_start = 1'b1;
          log_x = rdata_r;
          st_nxt = B_SLOG;
        end else if (idx_r == BIN_W'(BIN_N - 1)) begin
          st_nxt = B_NLOG;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt = B_SRD;
        end
      end
      B_SLOG: begin
        if (log_done) begin
          prod_nxt = ACC_W'(mul_p);
          st_nxt = B_SACC;
        end
      end
      B_SACC: begin
        s_nxt = s_r + prod_r;
        if (idx_r == BIN_W'(BIN_N - 1)) begin
          st_nxt = B_NLOG;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt = B_SRD;
        end
      end
      B_NLOG: begin
        log_start = 1'b1;
        log_x = cnt_r;
        st_nxt = B_NWAIT;
      end
      B_NWAIT: begin
        if (log_done) begin
          prod_nxt = ACC_W'(mul_p);
          st_nxt = B_NMUL;
        end
      end
      B_NMUL: begin
        dvd_nxt = DVD_W'(tdiff) + DVD_W'(cnt_r >> 1);
        rem_nxt = '0;
        dstep_nxt = 6'(DVD_W);
        st_nxt = B_DIV;
      end
      B_DIV: begin
        if (rem2 >= {1'b0, cnt_r}) begin
          rem_nxt = CNT_W'(rem2 - {1'b0, cnt_r});
          dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[CNT_W-1:0];
          dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        end
        dstep_nxt = dstep_r - 1'b1;
        if (dstep_r == 6'd1) st_nxt = B_EMUL;
      end
      B_EMUL: begin
        eprod_nxt = dvd_r[25:0] * LN2_Q32;
        qhi_nxt = |dvd_r[DVD_W-1:26];
        st_nxt = B_OUT;
      end
      B_OUT: begin
        ov_nxt = 1'b1;
        ow_nxt.pixel_total = cnt_r;
        if (cnt_r == '0) begin
          ow_nxt.entropy = '0;
        end else if (qhi_r || e > 23'(ENTROPY_MAX)) begin
          ow_nxt.entropy = ENTROPY_MAX;
        end else begin
          ow_nxt.entropy = e[18:0];
        end
        cnt_nxt = '0;
        st_nxt = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_CLR;
      idx_r <= '0;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    last_r <= last_nxt;
    c_r <= c_nxt;
    s_r <= s_nxt;
    prod_r <= prod_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dstep_r <= dstep_nxt;
    eprod_r <= eprod_nxt;
    qhi_r <= qhi_nxt;
    ow_r <= ow_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_r <= mem[raddr];
  end

endmodule

[src/channel_histogram_entropy.sv]
// top level: 256-bin channel histogram with shannon entropy readout
// pixels are counted one at a time by a read-modify-write on the bin memory
// a four-word queue lets start be taken every cycle until it fills
// after a last pixel the bin scan reads each bin and runs a log2 on each bin >= 2,
// then a log of the pixel total, a divide and a scale before the one-cycle out_valid strobe
// reset runs a clearing pass over all 256 bins with busy high; the receiver cannot stall
module channel_histogram_entropy (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  chne_pkg::in_word_t  in_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data,
  output logic                out_valid,
  output chne_pkg::out_word_t out_word
);
  import chne_pkg::*;

  logic       push, pop, q_empty, q_full;
  q_word_t    push_word, pop_word;
  back_stat_t stat;

  chne_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .q_full(q_full), .stat(stat), .push(push), .push_word(push_word)
  );

  chne_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_word(push_word), .pop(pop),
    .pop_word(pop_word), .empty(q_empty), .full(q_full)
  );

  chne_back u_back (
    .clk(clk), .rst_n(rst_n), .q_word(pop_word), .q_empty(q_empty), .pop(pop),
    .stat(stat), .out_valid(out_valid), .out_word(out_word)
  );

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> busy) else $error("accepting during clearing pass");

  a_no_out_clr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !stat.clearing) else $error("result during clearing pass");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (stat.idle && !q_empty)) else $error("queue pop outside idle");

endmodule

[test/channel_histogram_entropy_tb.sv]
// testbench for the channel histogram entropy block: directed and random images
`timescale 1ns / 100ps
module channel_histogram_entropy_tb;
  import chne_pkg::*;

  localparam logic [1:0] SEL_RED = 2'd2;
  localparam logic [1:0] SEL_RED_ALIAS = 2'd3;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int SETTLE_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = '0;
  logic out_valid;
  out_word_t out_word;

  out_word_t entropy_expected[$];
  int unsigned hist_model[BIN_N];
  int unsigned count_model;
  logic [1:0] sel_model;
  int errors = 0;
  int idle_cycles = 0;

  channel_histogram_entropy dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned log2_fix(longint unsigned x);
    int k;
    longint unsigned y, r;
    if (x == 0) return 0;
    k = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    y = (k <= 31) ? (x << (31 - k)) : (x >> (k - 31));
    r = longint'(k) << LOG_FRAC;
    for (int i = LOG_FRAC; i > 0; i--) begin
      y = (y * y) >> 31;
      if (y >= (64'd1 << 32)) begin
        r |= 64'd1 << (i - 1);
        y >>= 1;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned entropy_of_hist();
    longint unsigned n, s, full, t, h2, e;
    n = count_model;
    s = 0;
    if (n == 0) return 0;
    for (int b = 0; b < BIN_N; b++)
      if (hist_model[b] >= 2) s += longint'(hist_model[b]) * log2_fix(hist_model[b]);
    full = n * log2_fix(n);
    t = (full > s) ? full - s : 0;
    h2 = (t + n / 2) / n;
    e = (h2 * 64'd2977044472 + (64'd1 << 35)) >> 36;
    return (e > ENTROPY_MAX) ? ENTROPY_MAX : e;
  endfunction

  task automatic count_pixel(in_word_t w);
    logic [7:0] byte_sel;
    out_word_t r;
    case (sel_model)
      SEL_BLUE: byte_sel = w.blue;
      SEL_GREEN: byte_sel = w.green;
      default: byte_sel = w.red;
    endcase
    if (count_model < MAX_PIXELS) begin
      hist_model[byte_sel]++;
      count_model++;
    end
    if (w.last_pixel) begin
      r.entropy = 19'(entropy_of_hist());
      r.pixel_total = CNT_W'(count_model);
      entropy_expected.push_back(r);
      foreach (hist_model[b]) hist_model[b] = 0;
      count_model = 0;
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic last,
                            int gap);
    in_word_t w;
    w = '{blue: b, green: g, red: r, last_pixel: last};
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    count_pixel(w);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (entropy_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_select(logic [1:0] sel);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= sel;
    do @(posedge clk); while (!cfg_ready);
    sel_model = sel;
    cfg_valid <= 1'b0;
  endtask

  // one image: random bytes drawn from a pool so bins repeat
  task automatic send_image(int npix, int pool, bit gaps);
    logic [7:0] base;
    base = 8'($urandom);
    for (int i = 0; i < npix; i++)
      send_pixel(8'(base + $urandom_range(0, pool - 1)),
                 8'(base + $urandom_range(0, pool - 1)),
                 8'(base + $urandom_range(0, pool - 1)), i == npix - 1,
                 gaps ? pick_gap() : 0);
  endtask

  task automatic test_reset_select();
    send_pixel(8'd0, 8'd255, 8'd255, 1'b1, 0);
    send_pixel(8'd0, 8'd1, 8'd2, 1'b0, 0);
    send_pixel(8'd255, 8'd1, 8'd2, 1'b1, 0);
  endtask

  task automatic test_each_select();
    for (int s = 0; s < 4; s++) begin
      write_select(s[1:0]);
      send_pixel(8'h00, 8'h80, 8'hff, 1'b0, 0);
      send_pixel(8'hff, 8'h80, 8'h00, 1'b0, 1);
      send_pixel(8'h55, 8'h80, 8'haa, 1'b1, 0);
    end
  endtask

  task automatic test_wide_images();
    write_select(SEL_GREEN);
    for (int i = 0; i < BIN_N; i++)
      send_pixel(8'($urandom), i[7:0], 8'($urandom), i == BIN_N - 1, 0);
    for (int i = 0; i < 300; i++)
      send_pixel(8'($urandom), 8'h3c, 8'($urandom), i == 299, 0);
    write_select(SEL_RED);
    for (int i = 0; i < 512; i++)
      send_pixel(8'($urandom), 8'($urandom), i[7:0], i == 511, 0);
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 600) begin
      if ($urandom_range(0, 9) == 0) write_select(2'($urandom_range(0, 3)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
      send_image(n, ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 6),
                 $urandom_range(0, 3) != 0);
      sent += n;
    end
    write_select(SEL_RED_ALIAS);
    send_image(40, 4, 1'b1);
    write_select(SEL_BLUE);
    send_image(40, 256, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (entropy_expected.size() == 0) begin
        $display("%0t: unexpected result entropy=%0d total=%0d", $time,
                 out_word.entropy, out_word.pixel_total);
        errors++;
      end else begin
        if (out_word.entropy !== entropy_expected[0].entropy) begin
          $display("%0t: entropy expected %0d actual %0d", $time,
                   entropy_expected[0].entropy, out_word.entropy);
          errors++;
        end
        if (out_word.pixel_total !== entropy_expected[0].pixel_total) begin
          $display("%0t: pixel_total expected %0d actual %0d", $time,
                   entropy_expected[0].pixel_total, out_word.pixel_total);
          errors++;
        end
        void'(entropy_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    foreach (hist_model[b]) hist_model[b] = 0;
    count_model = 0;
    sel_model = SEL_BLUE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_select();
    test_each_select();
    test_wide_images();
    test_random();
    drain();
    if (errors == 0 && entropy_expected.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
